// ===== sv/ttptf_pkg.sv =====
// Shared types, constants and code tables for the paper tape frame generator.
// Used by the front, queue, back and top level modules; depends on nothing.
package ttptf_pkg;

   localparam int FRAMES_PER_CARD = 120;
   localparam int POS_W = $clog2(FRAMES_PER_CARD);
   localparam int MARKER_COUNT = (FRAMES_PER_CARD + 4) / 5;
   localparam int MARKER_W = (MARKER_COUNT > 1) ? $clog2(MARKER_COUNT) : 1;
   localparam int MARKER_LAST_RUN = FRAMES_PER_CARD - 5 * (MARKER_COUNT - 1) - 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] MARKER_FRAME = 8'o200;
   localparam logic [7:0] UNMAPPED_CODE = 8'o017;
   localparam logic [15:0] CP_LF = 16'd10;
   localparam logic [15:0] CP_CR = 16'd13;
   localparam logic [15:0] CP_GS = 16'h001D;
   localparam logic [15:0] CYRILLIC_FIRST = 16'h0410;
   localparam logic [15:0] CYRILLIC_END = 16'h0450;

   typedef enum logic [1:0] {
      BODY_NONE,
      BODY_FRAME,
      BODY_MARKER
   } body_type;

   typedef struct packed {
      logic       start;
      body_type   body;
      logic [7:0] frame;
      logic [6:0] zero_run;
      logic       tape_end;
   } cmd_type;

   localparam logic [7:0] ASCII_CODE [128] = '{
      8'o017, 8'o017, 8'o017, 8'o017, 8'o017, 8'o017, 8'o017, 8'o017,
      8'o017, 8'o017, 8'o214, 8'o017, 8'o017, 8'o017, 8'o017, 8'o017,
      8'o017, 8'o017, 8'o017, 8'o017, 8'o017, 8'o017, 8'o017, 8'o017,
      8'o017, 8'o017, 8'o017, 8'o017, 8'o017, 8'o017, 8'o174, 8'o017,
      8'o017, 8'o133, 8'o134, 8'o034, 8'o127, 8'o126, 8'o121, 8'o033,
      8'o022, 8'o023, 8'o031, 8'o012, 8'o015, 8'o013, 8'o016, 8'o014,
      8'o000, 8'o001, 8'o002, 8'o003, 8'o004, 8'o005, 8'o006, 8'o007,
      8'o010, 8'o011, 8'o037, 8'o026, 8'o035, 8'o025, 8'o036, 8'o136,
      8'o021, 8'o040, 8'o042, 8'o061, 8'o077, 8'o045, 8'o100, 8'o101,
      8'o055, 8'o102, 8'o103, 8'o052, 8'o104, 8'o054, 8'o105, 8'o056,
      8'o060, 8'o106, 8'o107, 8'o110, 8'o062, 8'o111, 8'o112, 8'o113,
      8'o065, 8'o063, 8'o114, 8'o027, 8'o017, 8'o030, 8'o115, 8'o132,
      8'o032, 8'o040, 8'o042, 8'o061, 8'o077, 8'o045, 8'o100, 8'o101,
      8'o055, 8'o102, 8'o103, 8'o052, 8'o104, 8'o054, 8'o105, 8'o056,
      8'o060, 8'o106, 8'o107, 8'o110, 8'o062, 8'o111, 8'o112, 8'o113,
      8'o065, 8'o063, 8'o114, 8'o017, 8'o130, 8'o017, 8'o123, 8'o017
   };

   localparam logic [7:0] CYRILLIC_CODE [32] = '{
      8'o040, 8'o041, 8'o042, 8'o043, 8'o044, 8'o045, 8'o046, 8'o047,
      8'o050, 8'o051, 8'o052, 8'o053, 8'o054, 8'o055, 8'o056, 8'o057,
      8'o060, 8'o061, 8'o062, 8'o063, 8'o064, 8'o065, 8'o066, 8'o067,
      8'o070, 8'o071, 8'o135, 8'o072, 8'o073, 8'o074, 8'o075, 8'o076
   };

   function automatic logic [7:0] special_code(input logic [15:0] cp);
      logic [7:0] code;
      unique case (cp)
         16'h00AC: code = 8'o123;
         16'h00B0: code = 8'o136;
         16'h00D7: code = 8'o024;
         16'h00F7: code = 8'o124;
         16'h2015: code = 8'o131;
         16'h2018: code = 8'o032;
         16'h2019: code = 8'o033;
         16'h2032: code = 8'o137;
         16'h203E: code = 8'o115;
         16'h212F: code = 8'o020;
         16'h2191: code = 8'o021;
         16'h2227: code = 8'o121;
         16'h2228: code = 8'o120;
         16'h2260: code = 8'o034;
         16'h2261: code = 8'o125;
         16'h2264: code = 8'o116;
         16'h2265: code = 8'o117;
         16'h2283: code = 8'o122;
         16'h23E8: code = 8'o020;
         16'h25C7: code = 8'o127;
         16'h25CA: code = 8'o127;
         16'h2A7D: code = 8'o116;
         16'h2A7E: code = 8'o117;
         default:  code = UNMAPPED_CODE;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] map_point(input logic [15:0] cp);
      logic [7:0] code;
      if (cp[15:7] == '0) begin
         code = ASCII_CODE[cp[6:0]];
      end else if (cp >= CYRILLIC_FIRST && cp < CYRILLIC_END) begin
         code = CYRILLIC_CODE[cp[4:0] - 5'd16];
      end else begin
         code = special_code(cp);
      end
      return code;
   endfunction

   function automatic logic [7:0] add_parity(input logic [7:0] code);
      logic [7:0] framed;
      framed = (^code) ? code : (code | 8'h80);
      return framed;
   endfunction

endpackage

// ===== sv/text_to_paper_tape_frames_core.sv =====
// Top level of the 8-track paper tape frame generator.
// Instantiates ttptf_front, ttptf_queue and ttptf_back; depends on ttptf_pkg.
//
// The req channel takes one file byte, or an end-of-file mark, per word. The
// rsp channel gives tape frames; each carries a count of zero frames that
// follow it, a tape end flag on the tail frame, and a last flag on the final
// word caused by one input word. The csr port writes the text mode bit; any
// write restarts the tape; the user must make it only while the block is idle,
// which the block does not enforce. A word's results pass through the command
// queue and the output register to rsp. A word gives at most one result per
// cycle, so most words sustain one per cycle while rsp_stall is low; the start
// frame adds one result word, and a marker card gives 24. A four-entry command
// queue sits between the decoder and the frame expander; req_stall rises only
// when that queue is full, and rsp_stall holds the output register and backs
// the queue up. Reset is synchronous; it empties the queue and the output
// register, selects binary mode and returns the tape to its start.
module text_to_paper_tape_frames_core import ttptf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_file,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame,
   output logic [6:0] rsp_zero_run,
   output logic       rsp_tape_end,
   output logic       rsp_last
);

   logic    full;
   logic    push;
   logic    pop;
   logic    head_valid;
   cmd_type push_cmd;
   cmd_type head_cmd;

   assign req_stall = full;

   ttptf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_accept       (req_valid && !full),
      .req_data_byte    (req_data_byte),
      .req_end_of_file  (req_end_of_file),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   ttptf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   ttptf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_frame    (rsp_frame),
      .rsp_zero_run (rsp_zero_run),
      .rsp_tape_end (rsp_tape_end),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== sv/ttptf_front.sv =====
// Front end: accepts input words, decodes UTF-8, tracks tape phase and card position.
// Emits one command per word that yields results. Depends on ttptf_pkg.
module ttptf_front import ttptf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic          csr_write_data,
   input  logic          req_accept,
   input  logic [7:0]    req_data_byte,
   input  logic          req_end_of_file,
   output logic          push,
   output cmd_type       push_cmd
);

   typedef enum logic [2:0] {
      PH_STARTING,
      PH_BINARY,
      PH_RUNNING,
      PH_IMAGE,
      PH_TAIL
   } phase_type;

   phase_type        phase_ff, phase_in, eff_phase;
   logic             text_mode_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [7:0]       lead_ff, lead_in;
   logic [7:0]       second_ff, second_in;
   logic             cp_valid;
   logic [15:0]      cp;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      lead_in   = lead_ff;
      second_in = second_ff;
      cp_valid  = 1'b0;
      cp        = '0;
      push      = 1'b0;
      push_cmd.start    = (phase_ff == PH_STARTING);
      push_cmd.body     = BODY_NONE;
      push_cmd.frame    = '0;
      push_cmd.zero_run = '0;
      push_cmd.tape_end = 1'b0;
      eff_phase = phase_ff;
      if (phase_ff == PH_STARTING) begin
         eff_phase = text_mode_ff ? PH_RUNNING : PH_BINARY;
      end
      if (req_accept && phase_ff != PH_TAIL) begin
         phase_in = eff_phase;
         if (req_end_of_file) begin
            cnt_in            = '0;
            lead_in           = '0;
            second_in         = '0;
            push_cmd.body     = BODY_FRAME;
            push_cmd.tape_end = 1'b1;
            phase_in          = PH_TAIL;
         end else if (eff_phase == PH_BINARY) begin
            push_cmd.body  = BODY_FRAME;
            push_cmd.frame = req_data_byte;
         end else begin
            if (cnt_ff == 2'd1) begin
               if (!lead_ff[5]) begin
                  cnt_in   = '0;
                  cp_valid = 1'b1;
                  cp       = {5'd0, lead_ff[4:0], req_data_byte[5:0]};
               end else begin
                  second_in = req_data_byte;
                  cnt_in    = 2'd2;
               end
            end else if (cnt_ff == 2'd2) begin
               cnt_in   = '0;
               cp_valid = !(lead_ff == 8'hEF && second_ff == 8'hBB &&
                            req_data_byte == 8'hBF);
               cp       = {lead_ff[3:0], second_ff[5:0], req_data_byte[5:0]};
            end else begin
               cnt_in = '0;
               if (!req_data_byte[7]) begin
                  cp_valid = 1'b1;
                  cp       = {8'd0, req_data_byte};
               end else begin
                  lead_in = req_data_byte;
                  cnt_in  = 2'd1;
               end
            end
            if (cp_valid) begin
               if (eff_phase == PH_RUNNING) begin
                  if (cp == CP_GS) begin
                     phase_in = PH_IMAGE;
                     pos_in   = '0;
                  end else if (cp != CP_LF && cp != CP_CR) begin
                     push_cmd.body  = BODY_FRAME;
                     push_cmd.frame = add_parity(map_point(cp));
                  end
               end else if (cp == CP_LF) begin
                  push_cmd.body     = BODY_FRAME;
                  push_cmd.zero_run = 7'(POS_W'(FRAMES_PER_CARD - 1) - pos_ff);
                  pos_in            = '0;
               end else if (cp == CP_GS) begin
                  push_cmd.body = BODY_MARKER;
                  phase_in      = PH_RUNNING;
                  pos_in        = '0;
               end else if (cp != CP_CR) begin
                  push_cmd.body  = BODY_FRAME;
                  push_cmd.frame = add_parity(map_point(cp));
                  pos_in = (pos_ff == POS_W'(FRAMES_PER_CARD - 1)) ? '0 : pos_ff + 1'b1;
               end
            end
         end
         push = push_cmd.start || push_cmd.body != BODY_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         phase_ff     <= PH_STARTING;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         lead_ff      <= '0;
         second_ff    <= '0;
         text_mode_ff <= reset ? 1'b0 : csr_write_data;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         cnt_ff    <= cnt_in;
         lead_ff   <= lead_in;
         second_ff <= second_in;
      end
   end

endmodule

// ===== sv/ttptf_queue.sv =====
// Short command queue that decouples the front end from the frame expander.
// Depends on ttptf_pkg for the command type and depth.
module ttptf_queue import ttptf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type           mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== sv/ttptf_back.sv =====
// Back end: expands queued commands into result words held in an output register.
// Handles the start frame and the marker card run. Depends on ttptf_pkg.
module ttptf_back import ttptf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head_cmd,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame,
   output logic [6:0] rsp_zero_run,
   output logic       rsp_tape_end,
   output logic       rsp_last
);

   logic                rsp_valid_ff;
   logic [7:0]          frame_ff, frame_in;
   logic [6:0]          run_ff, run_in;
   logic                end_ff, end_in;
   logic                last_ff, last_in;
   logic                start_done_ff;
   logic [MARKER_W-1:0] idx_ff;
   logic                load;
   logic                show_start;

   assign load       = !rsp_valid_ff || !rsp_stall;
   assign show_start = head_cmd.start && !start_done_ff;
   assign pop        = load && head_valid && last_in;

   always_comb begin
      frame_in = '0;
      run_in   = '0;
      end_in   = 1'b0;
      last_in  = 1'b1;
      if (show_start) begin
         last_in = (head_cmd.body == BODY_NONE);
      end else if (head_cmd.body == BODY_MARKER) begin
         frame_in = MARKER_FRAME;
         last_in  = (idx_ff == MARKER_W'(MARKER_COUNT - 1));
         run_in   = last_in ? 7'(MARKER_LAST_RUN) : 7'd4;
      end else begin
         frame_in = head_cmd.frame;
         run_in   = head_cmd.zero_run;
         end_in   = head_cmd.tape_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         start_done_ff <= 1'b0;
         idx_ff        <= '0;
      end else if (load) begin
         rsp_valid_ff <= head_valid;
         if (head_valid) begin
            if (last_in) begin
               start_done_ff <= 1'b0;
               idx_ff        <= '0;
            end else if (show_start) begin
               start_done_ff <= 1'b1;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= frame_in;
         run_ff   <= run_in;
         end_ff   <= end_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_frame    = frame_ff;
   assign rsp_zero_run = run_ff;
   assign rsp_tape_end = end_ff;
   assign rsp_last     = last_ff;

endmodule

// ===== sv/ttptf_checker.sv =====
// Port-level checker for the paper tape frame generator, with its bind.
// Depends only on the top level's ports.
module ttptf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_frame,
   input logic [6:0] rsp_zero_run,
   input logic       rsp_tape_end,
   input logic       rsp_last
);

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame) &&
      $stable(rsp_zero_run) && $stable(rsp_tape_end) && $stable(rsp_last))
      else $error("Stalled result changed.");

   a_tail_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tape_end |-> rsp_last && rsp_frame == 8'd0 &&
      rsp_zero_run == 7'd0)
      else $error("Tail frame is malformed.");

   a_run_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_zero_run <= 7'd119)
      else $error("Zero run exceeds a card.");

endmodule

bind text_to_paper_tape_frames_core ttptf_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_frame    (rsp_frame),
   .rsp_zero_run (rsp_zero_run),
   .rsp_tape_end (rsp_tape_end),
   .rsp_last     (rsp_last)
);
